@@ hw/rtl/lcv_pkg.sv @@
// shared types and constants for the line clipper
package lcv_pkg;

    localparam logic [3:0] CODE_BOTTOM = 4'd1;
    localparam logic [3:0] CODE_LEFT   = 4'd2;
    localparam logic [3:0] CODE_TOP    = 4'd4;
    localparam logic [3:0] CODE_RIGHT  = 4'd8;

    localparam int MAX_CLIP_STEPS = 8;

    localparam logic [2:0] REG_WIN_X_MIN  = 3'd0;
    localparam logic [2:0] REG_WIN_X_MAX  = 3'd1;
    localparam logic [2:0] REG_WIN_Y_MIN  = 3'd2;
    localparam logic [2:0] REG_WIN_Y_MAX  = 3'd3;
    localparam logic [2:0] REG_VIEW_X_MIN = 3'd4;
    localparam logic [2:0] REG_VIEW_X_MAX = 3'd5;
    localparam logic [2:0] REG_VIEW_Y_MIN = 3'd6;
    localparam logic [2:0] REG_VIEW_Y_MAX = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CLIP_MUL,
        ST_CLIP_DIV,
        ST_CLIP_UPD,
        ST_MAP_MUL,
        ST_MAP_DIV,
        ST_MAP_UPD,
        ST_OUT
    } state_t;

    // datapath operation selected by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLIP_SETUP,
        OP_CLIP_WRITE,
        OP_MAP_SETUP,
        OP_MAP_WRITE,
        OP_RESULT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       div_start;
        logic [1:0] map_idx;
    } lcv_cmd_t;

    typedef struct packed {
        logic degenerate;
        logic accept;
        logic reject;
        logic div_done;
    } lcv_stat_t;

endpackage

@@ hw/rtl/lcv_divider.sv @@
// serial restoring divider, signed operands, quotient truncated toward zero
module lcv_divider #(
    parameter int NUM_BITS = 34,
    parameter int DEN_BITS = 17
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [NUM_BITS-1:0] num,
    input  logic signed [DEN_BITS-1:0] den,
    output logic                       done,
    output logic signed [NUM_BITS-1:0] quo
);
    localparam int CW = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] q_reg, q_next;
    logic [DEN_BITS:0]   r_reg, r_next;
    logic [DEN_BITS-1:0] d_reg, d_next;
    logic                neg_reg, neg_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DEN_BITS:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[DEN_BITS-1:0], q_reg[NUM_BITS-1]};
        if (start)
        begin
            q_next    = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
            d_next    = den[DEN_BITS-1] ? DEN_BITS'(-den) : DEN_BITS'(den);
            neg_next  = num[NUM_BITS-1] ^ den[DEN_BITS-1];
            r_next    = '0;
            cnt_next  = CW'(NUM_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo  = (d_reg == '0) ? '0 :
                  (neg_reg ? -$signed(q_reg) : $signed(q_reg));
endmodule

@@ hw/rtl/lcv_datapath.sv @@
// endpoint registers, outcodes, multiplier and divider
module lcv_datapath #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lcv_pkg::lcv_cmd_t            cmd,
    output lcv_pkg::lcv_stat_t           stat,
    input  logic signed [COORD_BITS-1:0] cfg_regs [8],
    input  logic [4*COORD_BITS-1:0]      in_data,
    output logic [9*COORD_BITS:0]        result
);
    import lcv_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam logic signed [DW-1:0] SMAX = DW'((1 << (COORD_BITS - 1)) - 1);
    localparam logic signed [DW-1:0] SMIN = -SMAX - DW'(1);

    logic signed [COORD_BITS-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [COORD_BITS-1:0] px_reg [4];
    logic                         acc_reg;
    logic signed [DW-1:0]         a_reg, b_reg, c_reg, base_reg;
    logic signed [PW-1:0]         prod;
    logic                         tgt_y_reg, which_reg;
    logic [3:0]                   c0, c1, co;
    logic signed [COORD_BITS-1:0] xl, xh, yl, yh;
    logic signed [PW-1:0]         quo;
    logic signed [PW:0]           sum;
    logic signed [COORD_BITS-1:0] satv;
    logic                         div_done;
    logic signed [COORD_BITS-1:0] mc;

    function automatic logic [3:0] outcode(
        input logic signed [COORD_BITS-1:0] x, y, l, h, bl, bh);
        logic [3:0] c;
        c = '0;
        if (y > bh) c |= CODE_TOP;
        if (y < bl) c |= CODE_BOTTOM;
        if (x > h)  c |= CODE_RIGHT;
        if (x < l)  c |= CODE_LEFT;
        return c;
    endfunction

    assign xl = cfg_regs[REG_WIN_X_MIN];
    assign xh = cfg_regs[REG_WIN_X_MAX];
    assign yl = cfg_regs[REG_WIN_Y_MIN];
    assign yh = cfg_regs[REG_WIN_Y_MAX];

    assign c0 = outcode(x0_reg, y0_reg, xl, xh, yl, yh);
    assign c1 = outcode(x1_reg, y1_reg, xl, xh, yl, yh);
    assign co = (c0 != '0) ? c0 : c1;

    assign stat.degenerate = (xh <= xl) || (yh <= yl);
    assign stat.accept     = (c0 | c1) == '0;
    assign stat.reject     = (c0 & c1) != '0;
    assign stat.div_done   = div_done;

    // product of the operands loaded by the setup beat, taken by the divider at start
    assign prod = a_reg * b_reg;

    lcv_divider #(.NUM_BITS(PW), .DEN_BITS(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (prod),
        .den   (c_reg),
        .done  (div_done),
        .quo   (quo)
    );

    // quotient fits well within PW bits, so a PW+1 sum cannot wrap
    assign sum  = {{1{base_reg[DW-1]}}, {(PW-DW){base_reg[DW-1]}}, base_reg} +
                  {quo[PW-1], quo};
    assign satv = (sum > (PW+1)'(SMAX)) ? SMAX[COORD_BITS-1:0] :
                  (sum < (PW+1)'(SMIN)) ? SMIN[COORD_BITS-1:0] :
                  sum[COORD_BITS-1:0];

    always_comb
    begin
        unique case (cmd.map_idx)
            2'd0:    mc = x0_reg;
            2'd1:    mc = y0_reg;
            2'd2:    mc = x1_reg;
            default: mc = y1_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                x0_reg  <= in_data[COORD_BITS-1:0];
                y0_reg  <= in_data[2*COORD_BITS-1:COORD_BITS];
                x1_reg  <= in_data[3*COORD_BITS-1:2*COORD_BITS];
                y1_reg  <= in_data[4*COORD_BITS-1:3*COORD_BITS];
                acc_reg <= 1'b0;
            end
            OP_CLIP_SETUP:
            begin
                which_reg <= (c0 == '0);
                if ((co & (CODE_RIGHT | CODE_LEFT)) != '0)
                begin
                    tgt_y_reg <= 1'b1;
                    a_reg     <= DW'(y1_reg) - DW'(y0_reg);
                    b_reg     <= (((co & CODE_RIGHT) != '0) ? DW'(xh) : DW'(xl))
                                 - DW'(x0_reg);
                    c_reg     <= DW'(x1_reg) - DW'(x0_reg);
                    base_reg  <= DW'(y0_reg);
                end
                else
                begin
                    tgt_y_reg <= 1'b0;
                    a_reg     <= DW'(x1_reg) - DW'(x0_reg);
                    b_reg     <= (((co & CODE_TOP) != '0) ? DW'(yh) : DW'(yl))
                                 - DW'(y0_reg);
                    c_reg     <= DW'(y1_reg) - DW'(y0_reg);
                    base_reg  <= DW'(x0_reg);
                end
            end
            OP_CLIP_WRITE:
            begin
                // edge coordinate comes back from b + start point
                if (tgt_y_reg)
                begin
                    if (which_reg)
                    begin
                        x1_reg <= COORD_BITS'(b_reg + DW'(x0_reg));
                        y1_reg <= satv;
                    end
                    else
                    begin
                        x0_reg <= COORD_BITS'(b_reg + DW'(x0_reg));
                        y0_reg <= satv;
                    end
                end
                else
                begin
                    if (which_reg)
                    begin
                        y1_reg <= COORD_BITS'(b_reg + DW'(y0_reg));
                        x1_reg <= satv;
                    end
                    else
                    begin
                        y0_reg <= COORD_BITS'(b_reg + DW'(y0_reg));
                        x0_reg <= satv;
                    end
                end
            end
            OP_MAP_SETUP:
            begin
                if (cmd.map_idx[0])
                begin
                    a_reg    <= DW'(mc) - DW'(yl);
                    b_reg    <= DW'(cfg_regs[REG_VIEW_Y_MAX]) -
                                DW'(cfg_regs[REG_VIEW_Y_MIN]);
                    c_reg    <= DW'(yh) - DW'(yl);
                    base_reg <= DW'(cfg_regs[REG_VIEW_Y_MIN]);
                end
                else
                begin
                    a_reg    <= DW'(mc) - DW'(xl);
                    b_reg    <= DW'(cfg_regs[REG_VIEW_X_MAX]) -
                                DW'(cfg_regs[REG_VIEW_X_MIN]);
                    c_reg    <= DW'(xh) - DW'(xl);
                    base_reg <= DW'(cfg_regs[REG_VIEW_X_MIN]);
                end
            end
            OP_MAP_WRITE:
                px_reg[cmd.map_idx] <= satv;
            OP_RESULT:
                acc_reg <= 1'b1;
            default:
            begin
            end
        endcase
    end

    assign result = acc_reg ?
        {px_reg[3], px_reg[2], px_reg[1], px_reg[0],
         y1_reg, x1_reg, y0_reg, x0_reg, 1'b1} : '0;
endmodule

@@ hw/rtl/lcv_ctrl.sv @@
// sequencer for the clip loop and viewport mapping
module lcv_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic               out_fire,
    input  lcv_pkg::lcv_stat_t stat,
    output lcv_pkg::lcv_cmd_t  cmd,
    output logic               idle,
    output logic               out_valid
);
    import lcv_pkg::*;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [1:0] idx_reg, idx_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                begin
                    state_next = ST_CHECK;
                    step_next  = '0;
                end
            ST_CHECK:
                if (stat.degenerate || (!stat.accept && (stat.reject ||
                    step_reg == 4'(MAX_CLIP_STEPS))))
                    state_next = ST_OUT;
                else if (stat.accept)
                begin
                    state_next = ST_MAP_MUL;
                    idx_next   = '0;
                end
                else
                    state_next = ST_CLIP_MUL;
            ST_CLIP_MUL: state_next = ST_CLIP_DIV;
            ST_CLIP_DIV: if (stat.div_done) state_next = ST_CLIP_UPD;
            ST_CLIP_UPD:
            begin
                state_next = ST_CHECK;
                step_next  = step_reg + 1'b1;
            end
            ST_MAP_MUL: state_next = ST_MAP_DIV;
            ST_MAP_DIV: if (stat.div_done) state_next = ST_MAP_UPD;
            ST_MAP_UPD:
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg == 2'd3) ? ST_OUT : ST_MAP_MUL;
            end
            ST_OUT: if (out_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op        = OP_NONE;
        cmd.div_start = 1'b0;
        cmd.map_idx   = idx_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_fire) cmd.op = OP_LOAD;
            ST_CHECK:
                if (!stat.degenerate && stat.accept)
                    cmd.op = OP_MAP_SETUP;
                else if (!stat.degenerate && !stat.reject &&
                         step_reg != 4'(MAX_CLIP_STEPS))
                    cmd.op = OP_CLIP_SETUP;
            ST_CLIP_MUL: cmd.div_start = 1'b1;
            ST_CLIP_UPD: cmd.op = OP_CLIP_WRITE;
            ST_MAP_MUL:  cmd.div_start = 1'b1;
            ST_MAP_UPD:
            begin
                // operands for the next coordinate, or flag the result done
                cmd.map_idx = idx_reg + 2'd1;
                cmd.op      = OP_MAP_SETUP;
                if (idx_reg == 2'd3) cmd.op = OP_RESULT;
            end
            default:     cmd.op = OP_NONE;
        endcase
        // mapped coordinate is written as soon as the quotient is ready
        if (state_reg == ST_MAP_DIV && stat.div_done)
            cmd.op = OP_MAP_WRITE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
        end
    end

    assign idle      = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
endmodule

@@ hw/rtl/line_clip_window_to_viewport_top.sv @@
// Cohen-Sutherland line clipper with window-to-viewport mapping. One segment
// is taken at a time: each clip step and each of the four viewport mappings
// uses the one shared serial divider (one quotient bit per cycle over
// 2*COORD_BITS+2 bits). A segment that is rejected at once goes straight to
// the output without a clip step or mapping. The result is held in the output
// register until taken; a rejected segment returns all fields zero.
module line_clip_window_to_viewport_top #(
    parameter int COORD_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // start_x, start_y, end_x, end_y
    input  logic [4*COORD_BITS-1:0] s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // accepted, clip_start_x/y, clip_end_x/y, port_start_x/y, port_end_x/y, pad
    output logic [((9*COORD_BITS+1+7)/8)*8-1:0] m_axis_tdata,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [COORD_BITS-1:0]   cfg_data
);
    import lcv_pkg::*;

    localparam int OW = ((9 * COORD_BITS + 1 + 7) / 8) * 8;

    logic signed [COORD_BITS-1:0] cfg_reg [8];
    lcv_cmd_t                     cmd;
    lcv_stat_t                    stat;
    logic                         idle;
    logic [9*COORD_BITS:0]        result;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_WIN_X_MIN]  <= COORD_BITS'(800);
            cfg_reg[REG_WIN_X_MAX]  <= COORD_BITS'(1600);
            cfg_reg[REG_WIN_Y_MIN]  <= COORD_BITS'(800);
            cfg_reg[REG_WIN_Y_MAX]  <= COORD_BITS'(1600);
            cfg_reg[REG_VIEW_X_MIN] <= COORD_BITS'(3200);
            cfg_reg[REG_VIEW_X_MAX] <= COORD_BITS'(4800);
            cfg_reg[REG_VIEW_Y_MIN] <= COORD_BITS'(3200);
            cfg_reg[REG_VIEW_Y_MAX] <= COORD_BITS'(4800);
        end
        else if (cfg_valid)
            cfg_reg[cfg_index] <= cfg_data;
    end

    lcv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (s_axis_tvalid && idle),
        .out_fire  (m_axis_tvalid && m_axis_tready),
        .stat      (stat),
        .cmd       (cmd),
        .idle      (idle),
        .out_valid (m_axis_tvalid)
    );

    lcv_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .cfg_regs (cfg_reg),
        .in_data  (s_axis_tdata),
        .result   (result)
    );

    assign m_axis_tdata = OW'(result);
endmodule

@@ hw/rtl/lcv_checker.sv @@
// port-level checks for the line clipper
module lcv_checker #(
    parameter int DATA_W = 152
) (
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");
    a_rej: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata == '0)
        else $error("rejected segment with nonzero fields");
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result appeared in the beat after input");
endmodule

bind line_clip_window_to_viewport_top lcv_checker #(.DATA_W(OW)) u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
